>>> hdl/hsort_pkg.sv
// Shared types, constants and controller/datapath interface for the heap sorter.
`default_nettype none

package hsort_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_item;
    } elem_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     run_end;
        logic                     dropped;
    } sorted_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_BUILD_RD,
        ST_BUILD_CAP,
        ST_KIDS,
        ST_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    // Read address selection for the two store read ports
    typedef enum logic [2:0] {
        RD_NONE,
        RD_BUILD,
        RD_KIDS,
        RD_SWAP,
        RD_EMIT
    } rd_sel_t;

    typedef struct packed {
        logic    ld_ready;
        rd_sel_t rd;
        logic    prep;
        logic    build_cap;
        logic    cmp;
        logic    k_dec;
        logic    k_sort_init;
        logic    swap_wr;
        logic    emit_ld;
        logic    emit_pop;
        logic    clear_set;
    } cmd_t;

    typedef struct packed {
        logic in_last;
        logic n_lt2;
        logic k_one;
        logic child_wins;
        logic out_taken;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/hsort_ctrl.sv
// Sequencer for load, heap build, sort-down and emit phases.
`default_nettype none

module hsort_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsort_pkg::status_t status,
    output hsort_pkg::cmd_t        cmd
);

    hsort_pkg::state_t state_reg, state_next;
    logic              sorting_reg, sorting_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hsort_pkg::ST_LOAD;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sorting_reg <= sorting_next;
        end
    end

    // sorting_reg: 0 while building the heap, 1 while extracting the max
    always_comb
    begin
        sorting_next = sorting_reg;
        if (state_reg == hsort_pkg::ST_PREP)
        begin
            sorting_next = 1'b0;
        end
        else if (state_reg == hsort_pkg::ST_CMP && !status.child_wins && !sorting_reg
                 && status.k_one)
        begin
            sorting_next = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hsort_pkg::ST_LOAD:
            begin
                if (status.in_last)
                    state_next = hsort_pkg::ST_PREP;
            end
            hsort_pkg::ST_PREP:
            begin
                state_next = status.n_lt2 ? hsort_pkg::ST_EMIT_RD : hsort_pkg::ST_BUILD_RD;
            end
            hsort_pkg::ST_BUILD_RD:  state_next = hsort_pkg::ST_BUILD_CAP;
            hsort_pkg::ST_BUILD_CAP: state_next = hsort_pkg::ST_KIDS;
            hsort_pkg::ST_KIDS:      state_next = hsort_pkg::ST_CMP;
            hsort_pkg::ST_CMP:
            begin
                if (status.child_wins)
                    state_next = hsort_pkg::ST_KIDS;
                else if (sorting_reg)
                    state_next = status.k_one ? hsort_pkg::ST_EMIT_RD : hsort_pkg::ST_SWAP_RD;
                else
                    state_next = status.k_one ? hsort_pkg::ST_SWAP_RD : hsort_pkg::ST_BUILD_RD;
            end
            hsort_pkg::ST_SWAP_RD:   state_next = hsort_pkg::ST_SWAP_WR;
            hsort_pkg::ST_SWAP_WR:   state_next = hsort_pkg::ST_KIDS;
            hsort_pkg::ST_EMIT_RD:   state_next = hsort_pkg::ST_EMIT_LD;
            hsort_pkg::ST_EMIT_LD:   state_next = hsort_pkg::ST_EMIT_WAIT;
            hsort_pkg::ST_EMIT_WAIT:
            begin
                if (status.out_taken)
                    state_next = status.emit_last ? hsort_pkg::ST_LOAD : hsort_pkg::ST_EMIT_RD;
            end
            default: state_next = hsort_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd = hsort_pkg::RD_NONE;
        unique case (state_reg)
            hsort_pkg::ST_LOAD:      cmd.ld_ready = 1'b1;
            hsort_pkg::ST_PREP:      cmd.prep = 1'b1;
            hsort_pkg::ST_BUILD_RD:  cmd.rd = hsort_pkg::RD_BUILD;
            hsort_pkg::ST_BUILD_CAP: cmd.build_cap = 1'b1;
            hsort_pkg::ST_KIDS:      cmd.rd = hsort_pkg::RD_KIDS;
            hsort_pkg::ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (!status.child_wins)
                begin
                    if (!sorting_reg && status.k_one)
                        cmd.k_sort_init = 1'b1;
                    else if (!status.k_one)
                        cmd.k_dec = 1'b1;
                end
            end
            hsort_pkg::ST_SWAP_RD:   cmd.rd = hsort_pkg::RD_SWAP;
            hsort_pkg::ST_SWAP_WR:   cmd.swap_wr = 1'b1;
            hsort_pkg::ST_EMIT_RD:   cmd.rd = hsort_pkg::RD_EMIT;
            hsort_pkg::ST_EMIT_LD:   cmd.emit_ld = 1'b1;
            hsort_pkg::ST_EMIT_WAIT:
            begin
                cmd.emit_pop  = status.out_taken;
                cmd.clear_set = status.out_taken && status.emit_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/hsort_dp.sv
// Element store, sift compare, index registers and output register.
`default_nettype none

module hsort_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hsort_pkg::cmd_t    cmd,
    input  wire logic               elem_valid,
    input  wire hsort_pkg::elem_t   elem,
    input  wire logic               sorted_stall,
    output logic                    sorted_valid,
    output hsort_pkg::sorted_t      sorted,
    output hsort_pkg::status_t      status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;   // child index width, holds 2*node+2

    logic [hsort_pkg::DATA_W-1:0] store_mem [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] node_reg, node_next;
    logic [CW-1:0] hs_reg, hs_next;
    logic [AW-1:0] e_reg, e_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [hsort_pkg::DATA_W-1:0] node_val_reg, node_val_next;
    hsort_pkg::sorted_t out_reg, out_next;

    logic signed [hsort_pkg::DATA_W-1:0] rda_reg, rdb_reg;
    logic [AW-1:0] rd_addr_a, rd_addr_b;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [hsort_pkg::DATA_W-1:0]  wr_data;

    logic          load;
    logic          has_room;
    logic [LW-1:0] lc, rc, hs_ext;
    logic          l_gt, r_gt;
    logic signed [hsort_pkg::DATA_W-1:0] best_val, win_val;
    logic [LW-1:0] top_idx;
    logic          child_wins;
    logic          emit_last;

    assign load     = elem_valid && cmd.ld_ready;
    assign has_room = (count_reg < CW'(CAPACITY));

    // Sift compare: children of node_reg are in rda/rdb after ST_KIDS
    assign lc      = {1'b0, node_reg, 1'b1};
    assign rc      = lc + LW'(1);
    assign hs_ext  = LW'(hs_reg);
    assign l_gt     = (lc < hs_ext) && (rda_reg > node_val_reg);
    assign best_val = l_gt ? rda_reg : node_val_reg;
    assign r_gt     = (rc < hs_ext) && (rdb_reg > best_val);
    assign child_wins = l_gt || r_gt;
    assign win_val  = r_gt ? rdb_reg : rda_reg;
    assign top_idx  = r_gt ? rc : lc;

    assign emit_last = ((CW'(e_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (cmd.rd)
            hsort_pkg::RD_NONE:  ;
            hsort_pkg::RD_BUILD: rd_addr_a = k_reg - AW'(1);
            hsort_pkg::RD_KIDS:
            begin
                rd_addr_a = lc[AW-1:0];
                rd_addr_b = rc[AW-1:0];
            end
            hsort_pkg::RD_SWAP:  rd_addr_b = k_reg;
            hsort_pkg::RD_EMIT:  rd_addr_a = e_reg;
            default: ;
        endcase
    end

    // Sifting value rides in node_val_reg; the hole moves down the path
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (load && has_room)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = elem.value;
        end
        else if (cmd.cmp)
        begin
            wr_en   = 1'b1;
            wr_addr = node_reg;
            wr_data = child_wins ? win_val : node_val_reg;
        end
        else if (cmd.swap_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = k_reg;
            wr_data = rda_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rda_reg <= store_mem[rd_addr_a];
        rdb_reg <= store_mem[rd_addr_b];
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        node_next      = node_reg;
        hs_next        = hs_reg;
        e_next         = e_reg;
        node_val_next  = node_val_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (load)
        begin
            if (has_room)
                count_next = count_reg + CW'(1);
            else
                ovf_next = 1'b1;
        end
        if (cmd.prep)
        begin
            k_next = AW'(count_reg >> 1);
            e_next = '0;
        end
        if (cmd.k_dec)
            k_next = k_reg - AW'(1);
        if (cmd.k_sort_init)
            k_next = AW'(count_reg - CW'(1));
        if (cmd.build_cap)
        begin
            node_val_next = rda_reg;
            node_next     = k_reg - AW'(1);
            hs_next       = count_reg;
        end
        if (cmd.cmp && child_wins)
            node_next = top_idx[AW-1:0];
        if (cmd.swap_wr)
        begin
            node_val_next = rdb_reg;
            node_next     = '0;
            hs_next       = CW'(k_reg);
        end
        if (cmd.emit_ld)
        begin
            out_next.sorted_value = rda_reg;
            out_next.run_end      = emit_last;
            out_next.dropped      = ovf_reg;
            out_valid_next        = 1'b1;
        end
        if (cmd.emit_pop)
        begin
            out_valid_next = 1'b0;
            e_next         = e_reg + AW'(1);
        end
        if (cmd.clear_set)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            node_reg      <= '0;
            hs_reg        <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            node_reg      <= node_next;
            hs_reg        <= hs_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_val_reg <= node_val_next;
        out_reg      <= out_next;
    end

    assign sorted_valid = out_valid_reg;
    assign sorted       = out_reg;

    assign status.in_last    = load && elem.final_item;
    assign status.n_lt2      = (count_reg < CW'(2));
    assign status.k_one      = (k_reg == AW'(1));
    assign status.child_wins = child_wins;
    assign status.out_taken  = out_valid_reg && !sorted_stall;
    assign status.emit_last  = emit_last;

endmodule

`default_nettype wire

>>> hdl/heap_sorter.sv
// Top level of the heap sorter: controller plus datapath.
`default_nettype none

// Collects signed elements into a CAPACITY-entry store, one item per cycle while
// loading; the item flagged final_item closes the set. The set is then heap-sorted
// in place and emitted in ascending order, run_end on the last result and dropped
// on every result of a set that overflowed the store. No new element is taken
// from the moment the final item is accepted until the last result is taken.
// Each node a sift visits takes a child read, then a compare and write through
// the single store write port; each sift is set up by a read and a capture (build)
// or a swap read and write (sort-down), the build is prepared in ST_PREP, and each
// result is read, loaded and then held until taken. A set of n elements goes
// through about 1.5n sifts.
module heap_sorter #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               elem_valid,
    output logic                    elem_stall,
    input  wire hsort_pkg::elem_t   elem,
    output logic                    sorted_valid,
    input  wire logic               sorted_stall,
    output hsort_pkg::sorted_t      sorted
);

    hsort_pkg::cmd_t    cmd;
    hsort_pkg::status_t status;

    assign elem_stall = !cmd.ld_ready;

    hsort_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hsort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .elem_valid   (elem_valid),
        .elem         (elem),
        .sorted_stall (sorted_stall),
        .sorted_valid (sorted_valid),
        .sorted       (sorted),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for heap_sorter: directed table, then random sets.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY   = 64;
    localparam int N_DIR      = 24;
    localparam int RAND_ITEMS = 86;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYC  = 60;

    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    // Idle styles for both channels
    typedef enum int {
        IDLE_NONE,
        IDLE_SHORT,
        IDLE_LONG
    } idle_mode_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               fixed;
        logic signed [31:0] want_value;
        logic               want_end;
        logic               want_drop;
    } dir_row_t;

    // Fixed rows are single-element sets, so their one result is known up front.
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{VMAX,       1'b1, 1'b1, VMAX,   1'b1, 1'b0},
        '{VMIN,       1'b1, 1'b1, VMIN,   1'b1, 1'b0},
        '{32'sd0,     1'b1, 1'b1, 32'sd0, 1'b1, 1'b0},
        '{-32'sd1,    1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
        '{VMAX,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{VMIN,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd0,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd1,    1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd5,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd5,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd5,     1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd100,   1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd50,    1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd50,   1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd100,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd7,     1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd1,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd2,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd3,     1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd4,     1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{VMIN,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{VMIN,       1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{VMAX,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{VMIN,       1'b1, 1'b0, 32'sd0, 1'b0, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               elem_valid;
    logic               elem_stall;
    hsort_pkg::elem_t   elem;
    logic               sorted_valid;
    logic               sorted_stall;
    hsort_pkg::sorted_t sorted;

    heap_sorter #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .elem_valid  (elem_valid),
        .elem_stall  (elem_stall),
        .elem        (elem),
        .sorted_valid(sorted_valid),
        .sorted_stall(sorted_stall),
        .sorted      (sorted)
    );

    // Stimulus, with a typed result where the row fixes one
    hsort_pkg::elem_t   stim_q[$];
    bit                 fixed_q[$];
    hsort_pkg::sorted_t fixed_res_q[$];

    // Predictor state: stored elements kept in ascending order
    logic signed [31:0] held_vals[$];
    logic               held_over;
    hsort_pkg::sorted_t sorted_due[$];

    int                 accept_idx;
    int                 err_cnt;
    int                 idle_cycles;
    logic signed [31:0] prev_val;
    idle_mode_t         in_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = VMAX;
            1:       v = VMIN;
            2:       v = $signed($urandom_range(0, 20)) - 32'sd10;
            3:       v = prev_val;
            default: v = $urandom;
        endcase
        prev_val = v;
        return v;
    endfunction

    function automatic int pick_gap(idle_mode_t m);
        int g;
        g = 0;
        if (m == IDLE_SHORT)
            g = $urandom_range(0, 2);
        else if (m == IDLE_LONG)
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        return g;
    endfunction

    task automatic add_item(logic signed [31:0] v, logic last, bit fixed,
                            hsort_pkg::sorted_t res);
        hsort_pkg::elem_t e;
        e.value      = v;
        e.final_item = last;
        stim_q.push_back(e);
        fixed_q.push_back(fixed);
        fixed_res_q.push_back(res);
    endtask

    // Store value if room; on the last item queue the ascending set or the fixed result.
    task automatic absorb_item(hsort_pkg::elem_t e);
        int                 pos;
        int                 n;
        hsort_pkg::sorted_t r;
        if (held_vals.size() < CAPACITY)
        begin
            pos = 0;
            while (pos < held_vals.size() && held_vals[pos] <= e.value)
                pos++;
            held_vals.insert(pos, e.value);
        end
        else
            held_over = 1'b1;
        if (e.final_item)
        begin
            n = held_vals.size();
            if (fixed_q[accept_idx])
                sorted_due.push_back(fixed_res_q[accept_idx]);
            else
            begin
                for (int k = 0; k < n; k++)
                begin
                    r.sorted_value = held_vals[k];
                    r.run_end      = (k == n - 1);
                    r.dropped      = held_over;
                    sorted_due.push_back(r);
                end
            end
            held_vals.delete();
            held_over = 1'b0;
        end
        accept_idx++;
    endtask

    task automatic check_result(hsort_pkg::sorted_t got);
        hsort_pkg::sorted_t want;
        if (sorted_due.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got value %0d end %0b drop %0b",
                     $time, got.sorted_value, got.run_end, got.dropped);
            err_cnt++;
        end
        else
        begin
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value)
            begin
                $display("%0t: sorted_value expected %0d got %0d",
                         $time, want.sorted_value, got.sorted_value);
                err_cnt++;
            end
            if (got.run_end !== want.run_end)
            begin
                $display("%0t: run_end expected %0b got %0b", $time, want.run_end, got.run_end);
                err_cnt++;
            end
            if (got.dropped !== want.dropped)
            begin
                $display("%0t: dropped expected %0b got %0b", $time, want.dropped, got.dropped);
                err_cnt++;
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_valid && !elem_stall) || (sorted_valid && !sorted_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (elem_valid && !elem_stall)
                absorb_item(elem);
            if (sorted_valid && !sorted_stall)
                check_result(sorted);
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("heap_sorter: mismatch");
                $finish;
            end
        end
    end

    // Result side back-pressure
    initial
    begin
        idle_mode_t out_mode;
        int         hold;
        int         span;
        sorted_stall = 1'b0;
        hold         = 0;
        span         = 0;
        out_mode     = IDLE_NONE;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                out_mode = idle_mode_t'($urandom_range(0, 2));
                span     = $urandom_range(20, 120);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                sorted_stall <= 1'b1;
            end
            else if (out_mode == IDLE_SHORT && $urandom_range(0, 3) == 0)
            begin
                hold = $urandom_range(0, 2);
                sorted_stall <= 1'b1;
            end
            else if (out_mode == IDLE_LONG && $urandom_range(0, 15) == 0)
            begin
                hold = $urandom_range(10, 40);
                sorted_stall <= 1'b1;
            end
            else
                sorted_stall <= 1'b0;
        end
    end

    // Build stimulus, drive it, drain and report
    initial
    begin
        hsort_pkg::sorted_t res;
        int                 total;
        int                 set_no;
        int                 set_len;
        int                 gap;
        elem_valid  = 1'b0;
        elem        = '0;
        held_over   = 1'b0;
        accept_idx  = 0;
        err_cnt     = 0;
        idle_cycles = 0;
        prev_val    = 32'sd0;
        in_mode     = IDLE_NONE;

        foreach (DIR_TAB[i])
        begin
            res.sorted_value = DIR_TAB[i].want_value;
            res.run_end      = DIR_TAB[i].want_end;
            res.dropped      = DIR_TAB[i].want_drop;
            add_item(DIR_TAB[i].value, DIR_TAB[i].last, DIR_TAB[i].fixed, res);
        end

        // Mostly small sets; one fills the store and overflows it
        res    = '0;
        total  = 0;
        set_no = 0;
        while (total < RAND_ITEMS || set_no <= 2)
        begin
            if (set_no == 2)
                set_len = CAPACITY + 1 + $urandom_range(0, 2);
            else if ($urandom_range(0, 3) == 0)
                set_len = 1;
            else
                set_len = $urandom_range(2, 9);
            for (int k = 0; k < set_len; k++)
                add_item(pick_value(), k == set_len - 1, 1'b0, res);
            total += set_len;
            set_no++;
        end

        @(posedge rst_n);
        @(negedge clk);
        foreach (stim_q[i])
        begin
            if (i % 16 == 0)
                in_mode = idle_mode_t'($urandom_range(0, 2));
            gap = pick_gap(in_mode);
            if (gap > 0)
            begin
                elem_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            elem_valid <= 1'b1;
            elem       <= stim_q[i];
            do
                @(posedge clk);
            while (elem_stall !== 1'b0);
            @(negedge clk);
        end
        elem_valid <= 1'b0;

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_cnt == 0 && sorted_due.size() == 0)
            $display("heap_sorter: match");
        else
            $display("heap_sorter: mismatch");
        $finish;
    end

endmodule
